>>> rtl/dtep_pkg.sv
// Shared types, constants and helper functions for the date text to epoch seconds block.
package dtep_pkg;

  localparam logic [4:0] MonthEnd = 5'd2;
  localparam logic [4:0] DayPos   = 5'd4;
  localparam logic [4:0] HourPos  = 5'd7;
  localparam logic [4:0] MinPos   = 5'd10;
  localparam logic [4:0] SecPos   = 5'd13;
  localparam logic [4:0] YearPos  = 5'd16;
  localparam logic [4:0] LastPos  = 5'd19;
  localparam logic [4:0] PosMax   = 5'd31;

  localparam int FieldW = 7;
  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DaysW  = 23;
  localparam int TodW   = 19;
  localparam int SecsW  = 39;

  localparam logic [YearW-1:0] BaseYear    = 14'd1999;
  localparam logic [YearW-1:0] LeapStart   = 14'd2000;
  localparam logic [11:0]      LeapsAtBase = 12'd484;
  localparam logic [MonthW-1:0] MonthMar   = 4'd2;

  typedef struct packed {
    logic              err;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
  } date_t;

  typedef struct packed {
    logic                    err;
    logic signed [DaysW-1:0] days;
    logic [TodW-1:0]         tod;
  } span_t;

  localparam logic [23:0] MonthName [12] = '{
    "Jan", "Feb", "Mar", "Apr", "May", "Jun",
    "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
  };

  // Unknown names map to January.
  function automatic logic [MonthW-1:0] month_index(input logic [23:0] letters);
    logic [MonthW-1:0] idx;
    idx = '0;
    for (int m = 11; m >= 0; m--) begin
      if (letters == MonthName[m]) begin
        idx = MonthW'(m);
      end
    end
    return idx;
  endfunction

  function automatic logic [8:0] days_before(input logic [MonthW-1:0] month);
    logic [8:0] d;
    case (month)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Exact quotient by 25 for any 14-bit value, by reciprocal multiplication.
  function automatic logic [9:0] div25(input logic [YearW-1:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'd41944;
    return p[29:20];
  endfunction

  function automatic logic [FieldW-1:0] add_digit7(input logic [FieldW-1:0] acc,
                                                   input logic [3:0] d);
    logic [10:0] t;
    t = 11'(acc) * 11'd10 + 11'(d);
    return t[FieldW-1:0];
  endfunction

  function automatic logic [YearW-1:0] add_digit14(input logic [YearW-1:0] acc,
                                                   input logic [3:0] d);
    logic [17:0] t;
    t = 18'(acc) * 18'd10 + 18'(d);
    return t[YearW-1:0];
  endfunction

endpackage

>>> rtl/dtep_parse.sv
// Character parser: gathers month letters and number fields and emits one date record per text.
module dtep_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dtep_pkg::date_t      out_date
);

  logic [4:0]                   pos, pos_next;
  logic [23:0]                  letters, letters_next;
  logic [dtep_pkg::FieldW-1:0]  day, day_next;
  logic [dtep_pkg::FieldW-1:0]  hour, hour_next;
  logic [dtep_pkg::FieldW-1:0]  minute, minute_next;
  logic [dtep_pkg::FieldW-1:0]  second, second_next;
  logic [dtep_pkg::YearW-1:0]   year, year_next;
  logic                         derr, derr_next;
  logic                         accept;
  logic                         is_digit;
  logic [3:0]                   digit;
  dtep_pkg::date_t              rec_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
  assign digit    = in_byte[3:0];

  always_comb begin
    letters_next = letters;
    day_next     = day;
    hour_next    = hour;
    minute_next  = minute;
    second_next  = second;
    year_next    = year;
    derr_next    = derr;
    if (pos <= dtep_pkg::MonthEnd) begin
      letters_next = {letters[15:0], in_byte};
    end else if (pos == dtep_pkg::DayPos || pos == dtep_pkg::DayPos + 5'd1) begin
      if (is_digit) day_next = dtep_pkg::add_digit7(day, digit);
      else derr_next = 1'b1;
    end else if (pos == dtep_pkg::HourPos || pos == dtep_pkg::HourPos + 5'd1) begin
      if (is_digit) hour_next = dtep_pkg::add_digit7(hour, digit);
      else derr_next = 1'b1;
    end else if (pos == dtep_pkg::MinPos || pos == dtep_pkg::MinPos + 5'd1) begin
      if (is_digit) minute_next = dtep_pkg::add_digit7(minute, digit);
      else derr_next = 1'b1;
    end else if (pos == dtep_pkg::SecPos || pos == dtep_pkg::SecPos + 5'd1) begin
      if (is_digit) second_next = dtep_pkg::add_digit7(second, digit);
      else derr_next = 1'b1;
    end else if (pos >= dtep_pkg::YearPos && pos <= dtep_pkg::LastPos) begin
      if (is_digit) year_next = dtep_pkg::add_digit14(year, digit);
      else derr_next = 1'b1;
    end
    pos_next = (pos < dtep_pkg::PosMax) ? pos + 5'd1 : dtep_pkg::PosMax;

    rec_next.err    = (pos != dtep_pkg::LastPos) || derr_next;
    rec_next.year   = year_next;
    rec_next.month  = dtep_pkg::month_index(letters_next);
    rec_next.day    = day_next;
    rec_next.hour   = hour_next;
    rec_next.minute = minute_next;
    rec_next.second = second_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      letters   <= '0;
      day       <= '0;
      hour      <= '0;
      minute    <= '0;
      second    <= '0;
      year      <= '0;
      derr      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last) begin
          pos     <= '0;
          letters <= '0;
          day     <= '0;
          hour    <= '0;
          minute  <= '0;
          second  <= '0;
          year    <= '0;
          derr    <= 1'b0;
        end else begin
          pos     <= pos_next;
          letters <= letters_next;
          day     <= day_next;
          hour    <= hour_next;
          minute  <= minute_next;
          second  <= second_next;
          year    <= year_next;
          derr    <= derr_next;
        end
      end
      if (accept && in_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      out_date <= rec_next;
    end
  end

endmodule

>>> rtl/dtep_days.sv
// Day count stages: leap-year quotients first, then the day number and time of day.
module dtep_days (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dtep_pkg::date_t  in_date,
  output logic             out_valid,
  input  logic             out_ready,
  output dtep_pkg::span_t  out_span
);

  logic                        q_valid;
  logic                        q_ready;
  dtep_pkg::date_t             q_date;
  logic [9:0]                  q_y25;
  logic [11:0]                 q_n4;
  logic [9:0]                  q_n100;
  logic [9:0]                  q_n400;
  logic [dtep_pkg::YearW-1:0]  n_year;
  logic [dtep_pkg::YearW-1:0]  rem25;
  logic                        is_leap;
  logic [11:0]                 leaps;
  logic signed [14:0]          ydiff;
  logic signed [dtep_pkg::DaysW-1:0] year_days;
  logic signed [dtep_pkg::DaysW-1:0] days_sum;
  logic [dtep_pkg::TodW-1:0]   tod;
  dtep_pkg::span_t             span_next;

  assign q_ready  = !out_valid || out_ready;
  assign in_ready = !q_valid || q_ready;
  assign n_year   = in_date.year - 14'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_date <= in_date;
      q_y25  <= dtep_pkg::div25(in_date.year);
      q_n4   <= n_year[13:2];
      q_n100 <= dtep_pkg::div25(14'(n_year[13:2]));
      q_n400 <= dtep_pkg::div25(14'(n_year[13:4]));
    end
  end

  always_comb begin
    rem25   = q_date.year - 14'(q_y25) * 14'd25;
    is_leap = (q_date.year[1:0] == 2'b00) && ((rem25 != '0) || (q_date.year[3:0] == 4'd0));
    if (q_date.year > dtep_pkg::LeapStart) begin
      leaps = q_n4 - 12'(q_n100) + 12'(q_n400) - dtep_pkg::LeapsAtBase;
    end else begin
      leaps = '0;
    end
    ydiff     = $signed({1'b0, q_date.year}) - $signed({1'b0, dtep_pkg::BaseYear});
    year_days = dtep_pkg::DaysW'(ydiff) * 23'sd365;
    days_sum  = year_days
              + $signed(dtep_pkg::DaysW'(leaps))
              + $signed(dtep_pkg::DaysW'(dtep_pkg::days_before(q_date.month)))
              + $signed(dtep_pkg::DaysW'(q_date.month >= dtep_pkg::MonthMar && is_leap))
              + $signed(dtep_pkg::DaysW'(q_date.day))
              - 23'sd1;
    tod = dtep_pkg::TodW'(q_date.hour) * 19'd3600
        + dtep_pkg::TodW'(q_date.minute) * 19'd60
        + dtep_pkg::TodW'(q_date.second);
    span_next.err  = q_date.err;
    span_next.days = days_sum;
    span_next.tod  = tod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_ready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      out_span <= span_next;
    end
  end

endmodule

>>> rtl/dtep_secs.sv
// Seconds stage: scales the day count, adds the time of day and holds the result register.
module dtep_secs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dtep_pkg::span_t                   in_span,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dtep_pkg::SecsW-1:0] out_secs,
  output logic                              out_err
);

  logic signed [40:0]                 prod;
  logic signed [dtep_pkg::SecsW-1:0]  secs_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    prod = 41'($signed(in_span.days)) * 41'sd86400;
    secs_next = prod[dtep_pkg::SecsW-1:0]
              + $signed({20'd0, in_span.tod})
              - 39'sd6393600;
    if (in_span.err) begin
      secs_next = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_secs <= secs_next;
      out_err  <= in_span.err;
    end
  end

endmodule

>>> rtl/date_text_to_epoch_seconds.sv
// Top level of the date text to epoch seconds converter.
//
// Channel   Direction  Payload                                          Marker
// s_axis    in         tdata[7:0] text_byte                             tlast end_of_text
// m_axis    out        tdata[38:0] elapsed_seconds, tdata[39] zero      tuser format_error
//
// One byte is taken every cycle while tready is high; only the byte with tlast set produces
// a request on m_axis. That request passes the parser register, two day-count registers
// and the seconds result register, each fed by a short run of constant multiplies and adds.
// Reset clears the character counter, the field accumulators and all valid flags.
// A stall on m_axis holds each stage in place and backs up to s_axis_tready.
module date_text_to_epoch_seconds (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [38:0] elapsed_seconds, [39] zero fill
  output logic        m_axis_tuser    // [0] format_error
);

  logic                              date_valid;
  logic                              date_ready;
  dtep_pkg::date_t                   date_rec;
  logic                              span_valid;
  logic                              span_ready;
  dtep_pkg::span_t                   span_rec;
  logic signed [dtep_pkg::SecsW-1:0] secs;

  dtep_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_valid (date_valid),
    .out_ready (date_ready),
    .out_date  (date_rec)
  );

  dtep_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (date_valid),
    .in_ready  (date_ready),
    .in_date   (date_rec),
    .out_valid (span_valid),
    .out_ready (span_ready),
    .out_span  (span_rec)
  );

  dtep_secs u_secs (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (span_valid),
    .in_ready  (span_ready),
    .in_span   (span_rec),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_secs  (secs),
    .out_err   (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, secs};

endmodule
